// ----- src/ecpr_pkg.sv -----
package ecpr_pkg;

	localparam int ENTRIES_DEF   = 16;
	localparam int PAGE_BITS_DEF = 16;
	localparam int PAGE_W        = 16;
	localparam int SLOT_W        = 4;

	typedef struct packed {
		logic [PAGE_W-1:0] page_number;
		logic              is_write;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] slot_index;
		logic              victim_valid;
		logic [PAGE_W-1:0] victim_page;
		logic              needs_write_back;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic compare;
		logic hit_upd;
		logic scan_a;
		logic scan_b;
		logic fill;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic found;
	} status_t;

endpackage

// ----- src/ecpr_ctrl.sv -----
module ecpr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	input  ecpr_pkg::status_t st,
	output ecpr_pkg::cmd_t    cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CMP    = 3'd1;
	localparam logic [2:0] S_SCAN_A = 3'd2;
	localparam logic [2:0] S_SCAN_B = 3'd3;
	localparam logic [2:0] S_FILL   = 3'd4;

	logic [2:0] state_q, state_d;
	logic       rsp_valid_q;
	logic       out_free;
	logic       produce;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign produce   = cmd.hit_upd || cmd.fill;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CMP;
				end
			end
			S_CMP: begin
				cmd.compare = 1'b1;
				state_d     = S_SCAN_A;
			end
			S_SCAN_A: begin
				if (st.hit) begin
					// hold until the output register can take the transaction
					if (out_free) begin
						cmd.hit_upd = 1'b1;
						state_d     = S_IDLE;
					end
				end else begin
					cmd.scan_a = 1'b1;
					state_d    = st.found ? S_FILL : S_SCAN_B;
				end
			end
			S_SCAN_B: begin
				cmd.scan_b = 1'b1;
				state_d    = st.found ? S_FILL : S_SCAN_A;
			end
			S_FILL: begin
				if (out_free) begin
					cmd.fill = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (produce)
				rsp_valid_q <= 1'b1;
			else if (!rsp_stall)
				rsp_valid_q <= 1'b0;
		end
	end

endmodule

// ----- src/ecpr_dp.sv -----
module ecpr_dp #(
	parameter int ENTRIES   = ecpr_pkg::ENTRIES_DEF,
	parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ecpr_pkg::req_t    req,
	input  ecpr_pkg::cmd_t    cmd,
	output ecpr_pkg::status_t st,
	output ecpr_pkg::rsp_t    rsp
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SW = (PAGE_BITS < ecpr_pkg::PAGE_W) ? PAGE_BITS : ecpr_pkg::PAGE_W;
	localparam logic [IW:0] ENT = (IW+1)'(ENTRIES);

	logic [SW-1:0]      page_q;
	logic               wr_q;
	logic [SW-1:0]      slot_page_q [ENTRIES];
	logic [ENTRIES-1:0] loaded_q, used_q, dirty_q, match_q;
	logic [IW-1:0]      hand_q, chosen_q;
	ecpr_pkg::rsp_t     rsp_q;

	logic [ENTRIES-1:0]   scan_vec, rot, clr;
	logic [2*ENTRIES-1:0] dbl;
	logic [IW-1:0]        rot_pos, hit_idx, scan_slot, hand_next;
	logic [IW:0]          sum, span [ENTRIES];
	logic                 found;
	logic [ecpr_pkg::SLOT_W+IW-1:0] hit_ext, chosen_ext;
	logic [ecpr_pkg::PAGE_W+SW-1:0] vpage_ext;

	// rotate the candidate vector so that the hand sits at bit zero
	assign scan_vec = cmd.scan_b ? (~used_q & dirty_q) : (~used_q & ~dirty_q);
	assign dbl      = {scan_vec, scan_vec} >> hand_q;
	assign rot      = dbl[ENTRIES-1:0];
	assign found    = |rot;

	always_comb begin
		rot_pos = '0;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (rot[i]) rot_pos = IW'(i);
	end

	always_comb begin
		hit_idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--)
			if (match_q[i]) hit_idx = IW'(i);
	end

	assign sum       = {1'b0, hand_q} + {1'b0, rot_pos};
	assign scan_slot = (sum >= ENT) ? IW'(sum - ENT) : sum[IW-1:0];
	assign hand_next = ({1'b0, chosen_q} == ENT - 1'b1) ? '0 : IW'({1'b0, chosen_q} + 1'b1);

	// clear use bits of the slots passed over; all of them when nothing is found
	always_comb begin
		for (int s = 0; s < ENTRIES; s++) begin
			if (IW'(s) >= hand_q)
				span[s] = (IW+1)'(s) - {1'b0, hand_q};
			else
				span[s] = (IW+1)'(s) + ENT - {1'b0, hand_q};
			clr[s] = !found || (span[s] < {1'b0, rot_pos});
		end
	end

	assign st.hit   = |match_q;
	assign st.found = found;

	assign hit_ext    = {{ecpr_pkg::SLOT_W{1'b0}}, hit_idx};
	assign chosen_ext = {{ecpr_pkg::SLOT_W{1'b0}}, chosen_q};
	assign vpage_ext  = {{ecpr_pkg::PAGE_W{1'b0}}, slot_page_q[chosen_q]};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			page_q <= req.page_number[SW-1:0];
			wr_q   <= req.is_write;
		end
		if (cmd.compare)
			for (int s = 0; s < ENTRIES; s++)
				match_q[s] <= loaded_q[s] && (slot_page_q[s] == page_q);
		if ((cmd.scan_a || cmd.scan_b) && found)
			chosen_q <= scan_slot;
		if (cmd.fill)
			slot_page_q[chosen_q] <= page_q;
		if (cmd.hit_upd) begin
			rsp_q.hit              <= 1'b1;
			rsp_q.slot_index       <= hit_ext[ecpr_pkg::SLOT_W-1:0];
			rsp_q.victim_valid     <= 1'b0;
			rsp_q.victim_page      <= '0;
			rsp_q.needs_write_back <= 1'b0;
		end else if (cmd.fill) begin
			rsp_q.hit              <= 1'b0;
			rsp_q.slot_index       <= chosen_ext[ecpr_pkg::SLOT_W-1:0];
			rsp_q.victim_valid     <= loaded_q[chosen_q];
			rsp_q.victim_page      <= loaded_q[chosen_q] ?
				vpage_ext[ecpr_pkg::PAGE_W-1:0] : '0;
			rsp_q.needs_write_back <= loaded_q[chosen_q] && dirty_q[chosen_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
			used_q   <= '0;
			dirty_q  <= '0;
			hand_q   <= '0;
		end else begin
			if (cmd.scan_b)
				used_q <= used_q & ~clr;
			if (cmd.hit_upd) begin
				used_q[hit_idx] <= 1'b1;
				if (wr_q)
					dirty_q[hit_idx] <= 1'b1;
			end
			if (cmd.fill) begin
				loaded_q[chosen_q] <= 1'b1;
				used_q[chosen_q]   <= 1'b1;
				dirty_q[chosen_q]  <= wr_q;
				hand_q             <= hand_next;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

// ----- src/enhanced_clock_page_replacer_unit.sv -----
// Sequence: an accepted request is loaded, then compared; a hit is answered from the
// compare result, a miss runs up to two rounds of the clean and dirty sweeps, then the fill.
// One transaction at a time; the sweep sequencer does one rotated priority find per cycle.
// Reset: loaded, use and modified bits and the hand clear at once; stored page
// numbers are not cleared and no clearing pass runs.
module enhanced_clock_page_replacer_unit #(
	parameter int ENTRIES   = ecpr_pkg::ENTRIES_DEF,
	parameter int PAGE_BITS = ecpr_pkg::PAGE_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  ecpr_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output ecpr_pkg::rsp_t rsp
);

	ecpr_pkg::cmd_t    cmd;
	ecpr_pkg::status_t st;

	ecpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.st        (st),
		.cmd       (cmd)
	);

	ecpr_dp #(
		.ENTRIES   (ENTRIES),
		.PAGE_BITS (PAGE_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.st     (st),
		.rsp    (rsp)
	);

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.compare, cmd.hit_upd, cmd.scan_a, cmd.scan_b, cmd.fill}))
		else $error("more than one datapath command at once");

	a_load_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.compare)
		else $error("compare did not follow an accepted transaction");

	a_result_out: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.hit_upd || cmd.fill) |=> rsp_valid)
		else $error("finished transaction not presented");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.compare || cmd.scan_a || cmd.scan_b) |-> req_stall)
		else $error("input taken while a transaction is in flight");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int SLOTS     = ecpr_pkg::ENTRIES_DEF;
	localparam int HOT_PAGES = 24;
	localparam int RANDOM_N  = 1250;

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	ecpr_pkg::req_t req       = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	ecpr_pkg::rsp_t rsp;

	enhanced_clock_page_replacer_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #2 clk = ~clk;

	// resident-page table as the block should hold it
	logic [ecpr_pkg::PAGE_W-1:0] res_page   [SLOTS];
	logic                        res_loaded [SLOTS];
	logic                        res_used   [SLOTS];
	logic                        res_dirty  [SLOTS];
	int                          hand;

	ecpr_pkg::req_t pending_reqs[$];
	ecpr_pkg::rsp_t expected_rsps[$];
	ecpr_pkg::rsp_t want;
	int   n_total   = 0;
	int   n_sent    = 0;
	int   n_errors  = 0;
	int   hold_left = 0;
	bit   held      = 1'b0;
	logic [ecpr_pkg::PAGE_W-1:0] hot_pages [HOT_PAGES];

	function automatic ecpr_pkg::rsp_t replace_page(ecpr_pkg::req_t r);
		ecpr_pkg::rsp_t o;
		int   pick;
		int   s;
		o    = '0;
		pick = -1;
		for (int i = 0; i < SLOTS; i++) begin
			if (pick < 0 && res_loaded[i] && res_page[i] == r.page_number)
				pick = i;
		end
		if (pick >= 0) begin
			res_used[pick] = 1'b1;
			if (r.is_write)
				res_dirty[pick] = 1'b1;
			o.hit        = 1'b1;
			o.slot_index = pick[ecpr_pkg::SLOT_W-1:0];
			return o;
		end
		for (int rnd = 0; rnd < 2; rnd++) begin
			for (int k = 0; k < SLOTS; k++) begin
				s = (hand + k) % SLOTS;
				if (pick < 0 && !res_used[s] && !res_dirty[s])
					pick = s;
			end
			// second sweep clears use bits up to the dirty candidate
			for (int k = 0; k < SLOTS; k++) begin
				s = (hand + k) % SLOTS;
				if (pick < 0) begin
					if (!res_used[s] && res_dirty[s])
						pick = s;
					else
						res_used[s] = 1'b0;
				end
			end
		end
		if (res_loaded[pick]) begin
			o.victim_valid     = 1'b1;
			o.victim_page      = res_page[pick];
			o.needs_write_back = res_dirty[pick];
		end
		res_page[pick]   = r.page_number;
		res_loaded[pick] = 1'b1;
		res_used[pick]   = 1'b1;
		res_dirty[pick]  = r.is_write;
		hand             = (pick + 1) % SLOTS;
		o.slot_index     = pick[ecpr_pkg::SLOT_W-1:0];
		return o;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned exp_val);
		$display("MISMATCH %s: got %0h, expected %0h", what, got, exp_val);
		n_errors++;
	endtask

	task automatic queue_access(logic [ecpr_pkg::PAGE_W-1:0] pg, logic wr);
		ecpr_pkg::req_t r;
		r.page_number = pg;
		r.is_write    = wr;
		pending_reqs.push_back(r);
	endtask

	function automatic int phase_of();
		if (n_sent < n_total / 3)
			return 0;
		if (n_sent < 2 * n_total / 3)
			return 1;
		return 2;
	endfunction

	function automatic int sender_idle_pct();
		case (phase_of())
			0: return 36;
			1: return 51;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct();
		case (phase_of())
			0: return 51;
			1: return 36;
			default: return 0;
		endcase
	endfunction

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			res_page[i]   = '0;
			res_loaded[i] = 1'b0;
			res_used[i]   = 1'b0;
			res_dirty[i]  = 1'b0;
		end
		hand = 0;

		// fill every empty slot, extremes of the page number first
		queue_access(16'h0000, 1'b1);
		queue_access(16'hFFFF, 1'b0);
		for (int i = 2; i < SLOTS; i++)
			queue_access(16'h1000 + i[15:0], i[0]);
		// hits, read and write
		queue_access(16'h0000, 1'b0);
		queue_access(16'hFFFF, 1'b1);
		// all use bits set: full rounds of both sweeps
		queue_access(16'h5A5A, 1'b0);
		queue_access(16'hA5A5, 1'b1);
		queue_access(16'h8001, 1'b0);
		queue_access(16'h7FFE, 1'b1);
		queue_access(16'h0000, 1'b0);
		queue_access(16'hFFFF, 1'b0);

		for (int i = 0; i < HOT_PAGES; i++)
			hot_pages[i] = 16'($urandom_range(16'hFFFF));
		// mostly a working set a little larger than the table, some wide noise
		for (int i = 0; i < RANDOM_N; i++) begin
			if ($urandom_range(99) < 80)
				queue_access(hot_pages[$urandom_range(HOT_PAGES - 1)],
					1'($urandom_range(1)));
			else
				queue_access(16'($urandom_range(16'hFFFF)), 1'($urandom_range(1)));
		end
		n_total = pending_reqs.size();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (n_errors == 0 && expected_rsps.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#2000000;
		$display("Test completed with failures");
		$finish;
	end

	// driver: hold a stalled transaction, otherwise offer the next or idle
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				expected_rsps.push_back(replace_page(req));
				n_sent++;
			end
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
					req       <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off to back the block up
	always @(posedge clk) begin
		if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!held && n_sent >= 400) begin
			held      <= 1'b1;
			hold_left <= 300;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < receiver_idle_pct());
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				report_mismatch("unexpected transaction, slot", rsp.slot_index, 0);
			end else begin
				want = expected_rsps.pop_front();
				if (rsp.hit !== want.hit)
					report_mismatch("hit", rsp.hit, want.hit);
				if (rsp.slot_index !== want.slot_index)
					report_mismatch("slot_index", rsp.slot_index, want.slot_index);
				if (rsp.victim_valid !== want.victim_valid)
					report_mismatch("victim_valid", rsp.victim_valid, want.victim_valid);
				if (rsp.victim_page !== want.victim_page)
					report_mismatch("victim_page", rsp.victim_page, want.victim_page);
				if (rsp.needs_write_back !== want.needs_write_back)
					report_mismatch("needs_write_back", rsp.needs_write_back,
						want.needs_write_back);
			end
		end
	end

endmodule
